/* sv/tslnv_pkg.sv */
package tslnv_pkg;

   // Default sizes of the line counter and the printed number
   localparam int MAX_DIGITS_DEF = 8;
   localparam int MIN_WIDTH_DEF  = 6;

   // Entries in the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_NUMBER_LINES       = 3'd0;
   localparam logic [2:0] REG_SKIP_BLANK_NUMBERS = 3'd1;
   localparam logic [2:0] REG_SQUEEZE_BLANKS     = 3'd2;
   localparam logic [2:0] REG_MARK_LINE_ENDS     = 3'd3;
   localparam logic [2:0] REG_MARK_TABS          = 3'd4;
   localparam logic [2:0] REG_MARK_NONPRINTING   = 3'd5;

   // Character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_UPPER_I = 8'h49;
   localparam logic [7:0] CH_UPPER_M = 8'h4D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DEL    = 8'h7F;

   typedef struct packed {
      logic number_lines;
      logic skip_blank_numbers;
      logic squeeze_blanks;
      logic mark_line_ends;
      logic mark_tabs;
      logic mark_nonprinting;
   } cfg_type;

   // Bytes that follow the line number for one input byte
   typedef struct packed {
      logic [3:0][7:0] bytes;   // bytes[0] goes out first
      logic [2:0]      len;     // 1 to 4
   } body_type;

   // One queued command, apart from the counter snapshot
   typedef struct packed {
      logic     num;            // print the line number first
      body_type body;
   } cmd_type;

   // Expand one input byte into its displayed form
   function automatic body_type expand_byte(input logic [7:0] b, input cfg_type cfg);
      body_type   r;
      logic [7:0] low;
      logic [2:0] n;
      r.bytes = '0;
      r.len   = 3'd1;
      low     = {1'b0, b[6:0]};
      n       = 3'd0;
      if (b == CH_NL) begin
         if (cfg.mark_line_ends) begin
            r.bytes[0] = CH_DOLLAR;
            r.bytes[1] = CH_NL;
            r.len      = 3'd2;
         end else begin
            r.bytes[0] = CH_NL;
         end
      end else if (b == CH_TAB) begin
         if (cfg.mark_tabs) begin
            r.bytes[0] = CH_CARET;
            r.bytes[1] = CH_UPPER_I;
            r.len      = 3'd2;
         end else begin
            r.bytes[0] = CH_TAB;
         end
      end else if (!cfg.mark_nonprinting) begin
         r.bytes[0] = b;
      end else begin
         // high bytes get the M- prefix, then the low seven bits
         if (b[7]) begin
            r.bytes[0] = CH_UPPER_M;
            r.bytes[1] = CH_DASH;
            n          = 3'd2;
         end
         if (low < CH_SPACE) begin
            r.bytes[n[1:0]]        = CH_CARET;
            r.bytes[n[1:0] + 2'd1] = low + CH_AT;
            r.len                  = n + 3'd2;
         end else if (low == CH_DEL) begin
            r.bytes[n[1:0]]        = CH_CARET;
            r.bytes[n[1:0] + 2'd1] = CH_QUEST;
            r.len                  = n + 3'd2;
         end else begin
            r.bytes[n[1:0]] = low;
            r.len           = n + 3'd1;
         end
      end
      return r;
   endfunction

endpackage

/* sv/tslnv_front.sv */
module tslnv_front #(
   parameter int MAX_DIGITS = tslnv_pkg::MAX_DIGITS_DEF,
   parameter int SIG_W      = $clog2(MAX_DIGITS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tslnv_pkg::cfg_type      cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [7:0]              in_byte,
   output logic                    cmd_valid,
   input  logic                    cmd_ready,
   output tslnv_pkg::cmd_type      cmd,
   output logic [MAX_DIGITS*4-1:0] cmd_digits,
   output logic [SIG_W-1:0]        cmd_sig
);

   localparam int DW = MAX_DIGITS * 4;

   logic [MAX_DIGITS-1:0][3:0] digits_ff, digits_in;
   logic                       sol_ff, sol_in;
   logic                       blank_ff, blank_in;

   logic accept;
   logic is_nl;
   logic blank;
   logic squeeze;
   logic num;
   logic all_nine;
   logic carry;

   // Classify the incoming byte
   assign accept  = in_valid && in_ready;
   assign is_nl   = (in_byte == tslnv_pkg::CH_NL);
   assign blank   = sol_ff && is_nl;
   assign squeeze = cfg.squeeze_blanks && blank && blank_ff;
   assign num     = sol_ff && cfg.number_lines && !(cfg.skip_blank_numbers && blank);

   assign in_ready  = cmd_ready;
   assign cmd_valid = in_valid && !squeeze;

   assign cmd.num    = num;
   assign cmd.body   = tslnv_pkg::expand_byte(in_byte, cfg);
   assign cmd_digits = digits_ff;

   // Count significant digits of the current line number
   always_comb begin
      cmd_sig = SIG_W'(1);
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if (digits_ff[k] != 4'd0) begin
            cmd_sig = SIG_W'(k + 1);
         end
      end
   end

   // Advance the decimal counter on each numbered line, holding at all nines
   always_comb begin
      all_nine  = 1'b1;
      carry     = 1'b1;
      digits_in = digits_ff;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if (digits_ff[k] != 4'd9) begin
            all_nine = 1'b0;
         end
      end
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if (carry) begin
            if (digits_ff[k] >= 4'd9) begin
               digits_in[k] = 4'd0;
            end else begin
               digits_in[k] = digits_ff[k] + 4'd1;
               carry        = 1'b0;
            end
         end
      end
      if (all_nine || !(accept && !squeeze && num)) begin
         digits_in = digits_ff;
      end
   end

   // Track line start and blank line state
   always_comb begin
      sol_in   = sol_ff;
      blank_in = blank_ff;
      if (accept && !squeeze) begin
         sol_in   = is_nl;
         blank_in = blank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= DW'(1);
         sol_ff    <= 1'b1;
         blank_ff  <= 1'b0;
      end else begin
         digits_ff <= digits_in;
         sol_ff    <= sol_in;
         blank_ff  <= blank_in;
      end
   end

endmodule

/* sv/tslnv_queue.sv */
module tslnv_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = tslnv_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic push;
   logic pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/tslnv_back.sv */
module tslnv_back #(
   parameter int MAX_DIGITS = tslnv_pkg::MAX_DIGITS_DEF,
   parameter int MIN_WIDTH  = tslnv_pkg::MIN_WIDTH_DEF,
   parameter int SIG_W      = $clog2(MAX_DIGITS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   output logic                    cmd_ready,
   input  tslnv_pkg::cmd_type      cmd,
   input  logic [MAX_DIGITS*4-1:0] cmd_digits,
   input  logic [SIG_W-1:0]        cmd_sig,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [7:0]              out_byte,
   output logic                    out_last
);

   localparam int WMAX  = (MAX_DIGITS > MIN_WIDTH) ? MAX_DIGITS : MIN_WIDTH;
   localparam int CNT_W = $clog2(WMAX + 6);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;

   logic             load;
   logic             step;
   logic             last;
   logic [CNT_W-1:0] sig;
   logic [CNT_W-1:0] width;
   logic [CNT_W-1:0] num_len;
   logic [CNT_W-1:0] total;
   logic [CNT_W-1:0] pos;
   logic [CNT_W-1:0] body_idx;
   logic [IDX_W-1:0] dig_idx;
   logic [3:0]       digit;
   logic [7:0]       gen_byte;

   // Size the current command
   assign sig     = CNT_W'(cmd_sig);
   assign width   = (sig > CNT_W'(MIN_WIDTH)) ? sig : CNT_W'(MIN_WIDTH);
   assign num_len = cmd.num ? width + CNT_W'(1) : '0;
   assign total   = num_len + CNT_W'(cmd.body.len);
   assign last    = (cnt_ff == total - CNT_W'(1));

   // Pick the byte at the current step
   assign pos      = width - CNT_W'(1) - cnt_ff;
   assign dig_idx  = pos[IDX_W-1:0];
   assign digit    = cmd_digits[dig_idx*4 +: 4];
   assign body_idx = cnt_ff - num_len;

   always_comb begin
      if (cmd.num && (cnt_ff < width)) begin
         gen_byte = (pos >= sig) ? tslnv_pkg::CH_SPACE : tslnv_pkg::CH_ZERO + {4'd0, digit};
      end else if (cmd.num && (cnt_ff == width)) begin
         gen_byte = tslnv_pkg::CH_TAB;
      end else begin
         gen_byte = cmd.body.bytes[body_idx[1:0]];
      end
   end

   // Emit one beat per cycle while the output register is free
   assign load      = !out_valid_ff || out_ready;
   assign step      = load && cmd_valid;
   assign cmd_ready = step && last;

   always_comb begin
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_valid_in = cmd_valid;
         out_byte_in  = gen_byte;
         out_last_in  = last;
      end
      if (step) begin
         cnt_in = last ? '0 : cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

`ifndef SYNTHESIS
   a_cnt_in_range : assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> (cnt_ff < total))
      else $error("step count beyond command length");

   a_cnt_idle_zero : assert property (@(posedge clock) disable iff (reset)
      !cmd_valid |-> (cnt_ff == '0))
      else $error("step count left over without a command");

   a_pop_marks_last : assert property (@(posedge clock) disable iff (reset)
      cmd_ready |=> (out_valid_ff && out_last_ff))
      else $error("command retired without a last beat");
`endif

endmodule

/* sv/text_stream_line_numberer_visualizer.sv */
// Cooked text output filter. Each byte accepted on the req_ stream yields
// zero or more bytes on the rsp_ stream, with tlast on the final byte that
// the input byte caused; squeezed blank lines yield nothing. Line numbers,
// '$' line-end marks, ^I tabs and ^X / M- notation are enabled through six
// one-bit registers at byte addresses 0x00 to 0x14; write them only while
// the block is idle. The front classifies and counts lines at one byte per
// cycle while the queue has room and hands commands through a two-entry
// queue to the back, which emits one output byte per cycle while rsp_tready
// allows. An input byte expands to one output byte for plain text, two to
// four for marked bytes, plus max(digits, MIN_WIDTH) + 1 at a numbered
// line start; the output register is the limit on sustained rate.
module text_stream_line_numberer_visualizer #(
   parameter int MAX_DIGITS = tslnv_pkg::MAX_DIGITS_DEF,
   parameter int MIN_WIDTH  = tslnv_pkg::MIN_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] in_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // [7:0] out_byte
   output logic        rsp_tlast,     // last_of_run
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SIG_W  = $clog2(MAX_DIGITS + 1);
   localparam int DIG_W  = MAX_DIGITS * 4;
   localparam int CMD_W  = $bits(tslnv_pkg::cmd_type);
   localparam int Q_W    = CMD_W + DIG_W + SIG_W;

   tslnv_pkg::cfg_type cfg_ff, cfg_in;

   logic [2:0] reg_idx;
   logic       wr_en;

   logic                 f_valid;
   logic                 f_ready;
   tslnv_pkg::cmd_type   f_cmd;
   logic [DIG_W-1:0]     f_digits;
   logic [SIG_W-1:0]     f_sig;
   logic [Q_W-1:0]       q_in_data;
   logic [Q_W-1:0]       q_out_data;
   logic                 b_valid;
   logic                 b_ready;
   tslnv_pkg::cmd_type   b_cmd;
   logic [DIG_W-1:0]     b_digits;
   logic [SIG_W-1:0]     b_sig;

   // Register writes and reads
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tslnv_pkg::REG_NUMBER_LINES:       cfg_in.number_lines       = csr_pwdata[0];
            tslnv_pkg::REG_SKIP_BLANK_NUMBERS: cfg_in.skip_blank_numbers = csr_pwdata[0];
            tslnv_pkg::REG_SQUEEZE_BLANKS:     cfg_in.squeeze_blanks     = csr_pwdata[0];
            tslnv_pkg::REG_MARK_LINE_ENDS:     cfg_in.mark_line_ends     = csr_pwdata[0];
            tslnv_pkg::REG_MARK_TABS:          cfg_in.mark_tabs          = csr_pwdata[0];
            tslnv_pkg::REG_MARK_NONPRINTING:   cfg_in.mark_nonprinting   = csr_pwdata[0];
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tslnv_pkg::REG_NUMBER_LINES:       csr_prdata = {31'd0, cfg_ff.number_lines};
         tslnv_pkg::REG_SKIP_BLANK_NUMBERS: csr_prdata = {31'd0, cfg_ff.skip_blank_numbers};
         tslnv_pkg::REG_SQUEEZE_BLANKS:     csr_prdata = {31'd0, cfg_ff.squeeze_blanks};
         tslnv_pkg::REG_MARK_LINE_ENDS:     csr_prdata = {31'd0, cfg_ff.mark_line_ends};
         tslnv_pkg::REG_MARK_TABS:          csr_prdata = {31'd0, cfg_ff.mark_tabs};
         tslnv_pkg::REG_MARK_NONPRINTING:   csr_prdata = {31'd0, cfg_ff.mark_nonprinting};
         default:                           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tslnv_front #(
      .MAX_DIGITS (MAX_DIGITS),
      .SIG_W      (SIG_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd),
      .cmd_digits (f_digits),
      .cmd_sig    (f_sig)
   );

   // Pack command and counter snapshot for the queue
   assign q_in_data = {f_cmd, f_digits, f_sig};
   assign {b_cmd, b_digits, b_sig} = q_out_data;

   tslnv_queue #(
      .DATA_W (Q_W),
      .DEPTH  (tslnv_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_in_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (q_out_data)
   );

   tslnv_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .MIN_WIDTH  (MIN_WIDTH),
      .SIG_W      (SIG_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (b_valid),
      .cmd_ready  (b_ready),
      .cmd        (b_cmd),
      .cmd_digits (b_digits),
      .cmd_sig    (b_sig),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule
